>>> hw/rtl/tmr_pkg.sv
// shared types, field offsets and codes for the tile-map row renderer
package tmr_pkg;

    // map size in tiles
    localparam int MAP_TILES_WIDE = 128;
    localparam int MAP_TILES_HIGH = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_GFX_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH = 2'd2;

    localparam logic [23:0] GFX_BASE_RESET  = 24'h000000;
    localparam logic [10:0] TILE_BASE_RESET = 11'h141;
    localparam logic [7:0]  MAP_WIDTH_RESET = 8'd128;

    // request kinds carried in s_tuser
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_RENDER  = 1'b1;

    // map entry layout
    localparam int ENTRY_HFLIP = 11;
    localparam int ENTRY_VFLIP = 12;

    // input tdata layout, lowest field first
    localparam int S_TDATA_W    = 104;
    localparam int S_SLOT_LO    = 0;
    localparam int S_COLOR_LO   = 4;
    localparam int S_ENTRY_LO   = 36;
    localparam int S_TX_LO      = 52;
    localparam int S_TY_LO      = 59;
    localparam int S_ROW_LO     = 63;
    localparam int S_PIXELS_LO  = 66;

    // result tdata layout, lowest field first
    localparam int M_TDATA_W    = 96;

    // palette write request
    typedef struct packed {
        logic        en;
        logic [3:0]  slot;
        logic [31:0] color;
    } pal_wr_t;

    // row held in the row stage, one pixel picked per cycle by col while the result register takes it
    typedef struct packed {
        logic        valid;
        logic [2:0]  col;
        logic        hflip;
        logic [6:0]  tile_x;
        logic [31:0] pixels;
        logic [6:0]  pixel_y;
        logic [16:0] row_base;
        logic [23:0] fetch_addr;
    } pix_req_t;

endpackage

>>> hw/rtl/tile_map_row_render_top.sv
// top level of the tile-map row renderer
//
// Renders one 8-pixel row of an 8x8 tile packed at four bits per pixel. A render
// request (s_tuser = 1) with a tile at or above tile_base and inside the map gives
// eight results, source column order, m_tlast on the eighth; other render requests
// give none. A palette request (s_tuser = 0) writes one palette slot and gives no
// result. A render request holds the row stage until its eighth pixel is taken,
// one pixel per cycle into the result register unless m_tready stalls; the next
// request is taken in the cycle the eighth pixel moves into the result register.
// Palette and skipped requests do not hold the stage. Palette slots must be written
// before a pixel uses them. The user must write configuration only while idle; unchecked.
module tile_map_row_render_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // palette_slot, palette_color, map_entry, tile_x, tile_y, tile_row, row_pixels
    input  logic [tmr_pkg::S_TDATA_W-1:0]      s_tdata,
    // command
    input  logic                               s_tuser,
    // pixel results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_x, pixel_y, pixel_offset, color_index, pixel_color, row_fetch_address
    output logic [tmr_pkg::M_TDATA_W-1:0]      m_tdata,
    // last_pixel
    output logic                               m_tlast,
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tmr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tmr_pkg::*;

    logic [23:0] gfx_base_reg;
    logic [10:0] tile_base_reg;
    logic [7:0]  map_width_reg;

    pix_req_t    req;
    pal_wr_t     pal_wr;
    logic        pix_take;
    logic [3:0]  pal_slot;
    logic [31:0] pal_color;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gfx_base_reg  <= GFX_BASE_RESET;
            tile_base_reg <= TILE_BASE_RESET;
            map_width_reg <= MAP_WIDTH_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_GFX_BASE:  gfx_base_reg  <= cfg_data[23:0];
                REG_TILE_BASE: tile_base_reg <= cfg_data[10:0];
                REG_MAP_WIDTH: map_width_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tmr_row_stage u_row_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .gfx_base  (gfx_base_reg),
        .tile_base (tile_base_reg),
        .map_width (map_width_reg),
        .pix_take  (pix_take),
        .req       (req),
        .pal_wr    (pal_wr)
    );

    tmr_palette u_palette (
        .aclk     (aclk),
        .wr       (pal_wr),
        .rd_slot  (pal_slot),
        .rd_color (pal_color)
    );

    tmr_pixel_out u_pixel_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .pix_take  (pix_take),
        .pal_slot  (pal_slot),
        .pal_color (pal_color),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> hw/rtl/tmr_palette.sv
// 16-entry colour palette, one write and one read port
module tmr_palette (
    input  logic            aclk,
    input  tmr_pkg::pal_wr_t wr,
    input  logic [3:0]      rd_slot,
    output logic [31:0]     rd_color
);
    import tmr_pkg::*;

    logic [31:0] pal_reg [16];

    // slot write, contents undefined until written
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            pal_reg[wr.slot] <= wr.color;
        end
    end

    assign rd_color = pal_reg[rd_slot];

endmodule

>>> hw/rtl/tmr_row_stage.sv
// input register: takes requests, works out row constants, steps through eight pixels
module tmr_row_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tmr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                               s_tuser,
    input  logic [23:0]                        gfx_base,
    input  logic [10:0]                        tile_base,
    input  logic [7:0]                         map_width,
    input  logic                               pix_take,
    output tmr_pkg::pix_req_t                  req,
    output tmr_pkg::pal_wr_t                   pal_wr
);
    import tmr_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        hflip_reg, hflip_next;
    logic [6:0]  tx_reg, tx_next;
    logic [31:0] pixels_reg, pixels_next;
    logic [6:0]  py_reg, py_next;
    logic [16:0] base_reg, base_next;
    logic [23:0] addr_reg, addr_next;

    logic [15:0] entry;
    logic [10:0] tile;
    logic [6:0]  in_tx;
    logic [3:0]  in_ty;
    logic [2:0]  in_row;
    logic        s_accept;
    logic        hit;
    logic [10:0] tile_diff;
    logic [6:0]  in_py;
    logic [14:0] py_times_w;
    logic [17:0] row_base_wide;
    logic        finishing;

    // unpack request fields
    assign entry  = s_tdata[S_ENTRY_LO +: 16];
    assign tile   = entry[10:0];
    assign in_tx  = s_tdata[S_TX_LO +: 7];
    assign in_ty  = s_tdata[S_TY_LO +: 4];
    assign in_row = s_tdata[S_ROW_LO +: 3];

    // last pixel leaving frees the stage in the same cycle
    assign finishing = busy_reg && pix_take && (cnt_reg == 3'd7);
    assign s_tready  = !busy_reg || finishing;
    assign s_accept  = s_tvalid && s_tready;

    // palette writes land at once; pixels already sent used the old colour
    assign pal_wr.en    = s_accept && (s_tuser == CMD_PALETTE);
    assign pal_wr.slot  = s_tdata[S_SLOT_LO +: 4];
    assign pal_wr.color = s_tdata[S_COLOR_LO +: 32];

    // tile in range and on the map
    assign hit = (tile >= tile_base)
              && (32'(in_tx) < MAP_TILES_WIDE)
              && (32'(in_ty) < MAP_TILES_HIGH);

    // row constants
    assign tile_diff     = tile - tile_base;
    assign in_py         = {in_ty, entry[ENTRY_VFLIP] ? ~in_row : in_row};
    assign py_times_w    = 15'(in_py) * 15'(map_width);
    assign row_base_wide = {py_times_w, 3'b000};

    // next-state logic
    always_comb begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        hflip_next  = hflip_reg;
        tx_next     = tx_reg;
        pixels_next = pixels_reg;
        py_next     = py_reg;
        base_next   = base_reg;
        addr_next   = addr_reg;
        if (busy_reg && pix_take) begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
            end
        end
        if (s_accept && (s_tuser == CMD_RENDER) && hit) begin
            busy_next   = 1'b1;
            cnt_next    = 3'd0;
            hflip_next  = entry[ENTRY_HFLIP];
            tx_next     = in_tx;
            pixels_next = s_tdata[S_PIXELS_LO +: 32];
            py_next     = in_py;
            base_next   = row_base_wide[16:0];
            addr_next   = gfx_base + 24'({tile_diff, in_row, 2'b00});
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // row payload
    always_ff @(posedge aclk) begin
        hflip_reg  <= hflip_next;
        tx_reg     <= tx_next;
        pixels_reg <= pixels_next;
        py_reg     <= py_next;
        base_reg   <= base_next;
        addr_reg   <= addr_next;
    end

    assign req.valid      = busy_reg;
    assign req.col        = cnt_reg;
    assign req.hflip      = hflip_reg;
    assign req.tile_x     = tx_reg;
    assign req.pixels     = pixels_reg;
    assign req.pixel_y    = py_reg;
    assign req.row_base   = base_reg;
    assign req.fetch_addr = addr_reg;

    // a stalled row holds its place
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !pix_take) |=> (busy_reg && $stable(cnt_reg)))
        else $error("row stage moved while stalled");

    // pixels step one column at a time
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && pix_take && (cnt_reg != 3'd7))
            |=> (busy_reg && (cnt_reg == $past(cnt_reg) + 3'd1)))
        else $error("row stage skipped a pixel");

    // eighth pixel frees the stage unless a new row is loaded
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (finishing && !(s_accept && (s_tuser == CMD_RENDER) && hit)) |=> !busy_reg)
        else $error("row stage not released after eighth pixel");

    // a render request only loads into a free stage
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && busy_reg) |-> finishing)
        else $error("request taken while row still in progress");

endmodule

>>> hw/rtl/tmr_pixel_out.sv
// per-pixel position, offset and colour into the result register
module tmr_pixel_out (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tmr_pkg::pix_req_t                  req,
    output logic                               pix_take,
    output logic [3:0]                         pal_slot,
    input  logic [31:0]                        pal_color,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tmr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);
    import tmr_pkg::*;

    logic        valid_reg, valid_next;
    logic [9:0]  px_reg;
    logic [6:0]  py_reg;
    logic [16:0] off_reg;
    logic [3:0]  idx_reg;
    logic [31:0] color_reg;
    logic [23:0] addr_reg;
    logic        last_reg;

    logic [4:0]  nib_shift;
    logic [31:0] shifted;
    logic [3:0]  nibble;
    logic [9:0]  px;
    logic [16:0] off;

    // pick the nibble, high nibble of each byte is the left pixel
    assign nib_shift = 5'd28 - {req.col, 2'b00};
    assign shifted   = req.pixels >> nib_shift;
    assign nibble    = shifted[3:0];
    assign pal_slot  = nibble;

    // flipped column and linear offset
    assign px  = {req.tile_x, req.hflip ? ~req.col : req.col};
    assign off = req.row_base + 17'(px);

    // result register takes a pixel when empty or being emptied
    assign pix_take = req.valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (pix_take) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (pix_take) begin
            px_reg    <= px;
            py_reg    <= req.pixel_y;
            off_reg   <= off;
            idx_reg   <= nibble;
            color_reg <= pal_color;
            addr_reg  <= req.fetch_addr;
            last_reg  <= (req.col == 3'd7);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, addr_reg, color_reg, idx_reg, off_reg, py_reg, px_reg};

endmodule
